// ----- hdl/lwts_pkg.sv -----
// Package: payload types, command/status structs and sizing constants.
package lwts_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int LEN_W            = 11;
    localparam int TARGET_W         = 26;
    localparam int DEF_WINDOW_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS  = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                end_of_array;
    } t_in;

    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic             window_overflow;
        logic             array_done;
    } t_out;

    typedef struct packed {
        logic accept;
        logic drop;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_drop;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/lwts_store.sv -----
// Window store: one write port, one registered read port with write bypass.
module lwts_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lwts_ctrl.sv -----
// Controller: accepts a sample, runs the shrink loop, issues the result.
module lwts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lwts_pkg::t_status i_status,
    output logic              o_in_ready,
    output lwts_pkg::t_cmd    o_cmd
);

    import lwts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SHRINK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SHRINK;
                end
            end
            ST_SHRINK: begin
                if (i_status.need_drop) begin
                    o_cmd.drop = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/lwts_datapath.sv -----
// Datapath: window pointers, running sum, best length, target and result register.
module lwts_datapath #(
    parameter int WINDOW_DEPTH = lwts_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = lwts_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lwts_pkg::t_in                 i_in_data,
    input  logic                          i_cfg_we,
    input  logic [lwts_pkg::TARGET_W-1:0] i_cfg_data,
    input  lwts_pkg::t_cmd                i_cmd,
    input  logic                          i_out_ready,
    output lwts_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output lwts_pkg::t_out                o_out_data
);

    import lwts_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = ((SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W) + 1;

    logic [PTR_W-1:0]       r_oldest,  n_oldest;
    logic [PTR_W-1:0]       r_newest,  n_newest;
    logic [CNT_W-1:0]       r_count,   n_count;
    logic [SUM_W-1:0]       r_sum,     n_sum;
    logic [CNT_W-1:0]       r_best,    n_best;
    logic                   r_ovf,     n_ovf;
    logic                   r_last;
    logic [TARGET_W-1:0]    r_target;
    logic                   r_out_valid;
    t_out                   r_out;

    logic [SAMPLE_BITS-1:0] w_sample;
    logic [SAMPLE_BITS-1:0] w_head;
    logic                   w_full;
    logic [CNT_W-1:0]       w_best_upd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(WINDOW_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign w_sample = SAMPLE_BITS'(i_in_data.sample);
    assign w_full   = (r_count == CNT_W'(WINDOW_DEPTH));

    assign w_best_upd = ((r_sum == SUM_W'(r_target)) && (r_count > r_best)) ? r_count : r_best;

    assign o_status.need_drop = (r_sum > SUM_W'(r_target)) && (r_count != '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_oldest = r_oldest;
        n_newest = r_newest;
        n_count  = r_count;
        n_sum    = r_sum;
        n_best   = r_best;
        n_ovf    = r_ovf;
        if (i_cmd.accept) begin
            n_newest = ptr_inc(r_newest);
            if (w_full) begin
                n_oldest = ptr_inc(r_oldest);
                n_sum    = r_sum - SUM_W'(w_head) + SUM_W'(w_sample);
                n_ovf    = 1'b1;
            end else begin
                n_count  = r_count + 1'b1;
                n_sum    = r_sum + SUM_W'(w_sample);
            end
        end else if (i_cmd.drop) begin
            n_oldest = ptr_inc(r_oldest);
            n_count  = r_count - 1'b1;
            n_sum    = r_sum - SUM_W'(w_head);
        end else if (i_cmd.finish) begin
            if (r_last) begin
                n_oldest = '0;
                n_newest = '0;
                n_count  = '0;
                n_sum    = '0;
                n_best   = '0;
                n_ovf    = 1'b0;
            end else begin
                n_best   = w_best_upd;
            end
        end
    end

    lwts_store #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_newest),
        .i_wdata (w_sample),
        .i_raddr (n_oldest),
        .o_rdata (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_target    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_best   <= n_best;
            r_ovf    <= n_ovf;
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_last <= i_in_data.end_of_array;
        end
        if (i_cmd.finish) begin
            r_out.best_length     <= LEN_W'(w_best_upd);
            r_out.window_overflow <= r_ovf;
            r_out.array_done      <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/longest_window_with_target_sum.sv -----
// Top level: longest window whose sum equals the target, over a sample stream.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  in       | i_in_valid / o_in_ready    | i_in_data  (sample, end_of_array)
//  out      | o_out_valid / i_out_ready  | o_out_data (best_length, overflow, done)
//  cfg      | i_cfg_we                   | i_cfg_data (target_sum)
//
//  A sample is taken only when idle; the shrink loop then drops samples from the
//  window, reading one store entry per cycle, until the result is issued.
//  Reset is synchronous; the store needs no clearing pass.
//  A finished result holds in the output register; the next sample is taken
//  meanwhile and its result waits until that register is free.
module longest_window_with_target_sum #(
    parameter int WINDOW_DEPTH = lwts_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = lwts_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lwts_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lwts_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lwts_pkg::TARGET_W-1:0] i_cfg_data
);

    import lwts_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    lwts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    lwts_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input transfer taken while a sample is in work");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_status.out_free)
        else $error("result issued while output register occupied");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out_valid)
        else $error("issued result not presented");

    a_drop_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.drop |-> (w_status.need_drop && !o_in_ready))
        else $error("drop without need or outside shrink loop");

endmodule
